/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked condition that must never be true
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* design/iprtl_pkg.sv */
`default_nettype none

package iprtl_pkg;

   // field widths
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 13;
   localparam int SLOT_W  = 12;

   // one table entry: start, end and record pointer side by side
   localparam int ENTRY_W = 3 * WORD_W;

   // default table capacity
   localparam int DEF_MAX_ENTRIES = 4096;

   // item kinds
   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

endpackage

`default_nettype wire

/* design/ip_range_table_lookup.sv */
// Loads write one entry in the cycle they are accepted; one per cycle while idle, no result.
// A query does p probes of the entry RAM, one per cycle; p depends on the address and is
// at most ceil(log2(min(entry_count, MAX_ENTRIES) + 1)), 13 for 4096 entries.
// Then the candidate entry is checked against its end (skipped if nothing starts at or below
// the address); the result moves to the output register once free; then requests are taken.
// Synchronous active-high reset clears entry_count and control; table undefined until loaded.
`default_nettype none

module ip_range_table_lookup #(
   parameter int MAX_ENTRIES = iprtl_pkg::DEF_MAX_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [iprtl_pkg::SLOT_W-1:0] req_slot,
   input  logic [iprtl_pkg::WORD_W-1:0] req_range_start,
   input  logic [iprtl_pkg::WORD_W-1:0] req_range_end,
   input  logic [iprtl_pkg::WORD_W-1:0] req_record_pointer,
   input  logic [iprtl_pkg::WORD_W-1:0] req_address,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [iprtl_pkg::COUNT_W-1:0] rsp_entry_number,
   output logic [iprtl_pkg::WORD_W-1:0]  rsp_match_start,
   output logic [iprtl_pkg::WORD_W-1:0]  rsp_match_end,
   output logic [iprtl_pkg::WORD_W-1:0]  rsp_match_record,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [iprtl_pkg::COUNT_W-1:0] csr_wr_data
);

   import iprtl_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] entry_count_ff;
   logic               pending_ff, pending_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic [WORD_W-1:0]  addr_ff, addr_in;

   logic               res_found_ff, res_found_in;
   logic [COUNT_W-1:0] res_number_ff, res_number_in;
   logic [WORD_W-1:0]  res_start_ff, res_start_in;
   logic [WORD_W-1:0]  res_end_ff, res_end_in;
   logic [WORD_W-1:0]  res_record_ff, res_record_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_number_ff, rsp_number_in;
   logic [WORD_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [WORD_W-1:0]  rsp_end_ff, rsp_end_in;
   logic [WORD_W-1:0]  rsp_record_ff, rsp_record_in;

   logic               req_accept;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [WORD_W-1:0]  rd_start, rd_end, rd_record;

   logic [CW-1:0]      hi_cap;
   logic [CW-1:0]      lo_step, hi_step;
   logic [CW:0]        mid_sum;
   logic [AW-1:0]      mid_next;
   logic [AW-1:0]      last_idx;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   // entry RAM: start, end and record pointer in one word
   assign ram_wr_en   = req_accept && (req_kind == KIND_LOAD)
                        && (32'(req_slot) < 32'(MAX_ENTRIES));
   assign ram_wr_addr = AW'(req_slot);
   assign ram_wr_data = {req_range_start, req_range_end, req_record_pointer};

   iprtl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_start  = ram_rd_data[2*WORD_W +: WORD_W];
   assign rd_end    = ram_rd_data[WORD_W +: WORD_W];
   assign rd_record = ram_rd_data[0 +: WORD_W];

   // search window limit, entry_count capped at capacity
   assign hi_cap = (32'(entry_count_ff) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                             : CW'(entry_count_ff);

   // narrow the window with the probe that just came back
   always_comb begin
      lo_step = lo_ff;
      hi_step = hi_ff;
      if (pending_ff) begin
         if (rd_start <= addr_ff) begin
            lo_step = CW'(mid_ff) + CW'(1);
         end else begin
            hi_step = CW'(mid_ff);
         end
      end
   end

   assign mid_sum  = (CW+1)'(lo_step) + (CW+1)'(hi_step);
   assign mid_next = AW'(mid_sum >> 1);
   assign last_idx = AW'(lo_step - CW'(1));

   // next probe address, or the candidate entry once the window is closed
   always_comb begin
      ram_rd_addr = mid_ff;
      if (state_ff == ST_STEP) begin
         ram_rd_addr = (lo_step < hi_step) ? mid_next : last_idx;
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      addr_in       = addr_ff;
      res_found_in  = res_found_ff;
      res_number_in = res_number_ff;
      res_start_in  = res_start_ff;
      res_end_in    = res_end_ff;
      res_record_in = res_record_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_number_in = rsp_number_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_record_in = rsp_record_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_kind == KIND_QUERY)) begin
               addr_in    = req_address;
               lo_in      = '0;
               hi_in      = hi_cap;
               pending_in = 1'b0;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (lo_step < hi_step) begin
               mid_in     = mid_next;
               pending_in = 1'b1;
            end else begin
               pending_in = 1'b0;
               if (lo_step == '0) begin
                  // nothing starts at or below the address
                  res_found_in  = 1'b0;
                  res_number_in = '0;
                  res_start_in  = '0;
                  res_end_in    = '0;
                  res_record_in = '0;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // candidate entry against its end
            if (addr_ff <= rd_end) begin
               res_found_in  = 1'b1;
               res_number_in = COUNT_W'(lo_ff);
               res_start_in  = rd_start;
               res_end_in    = rd_end;
               res_record_in = rd_record;
            end else begin
               res_found_in  = 1'b0;
               res_number_in = '0;
               res_start_in  = '0;
               res_end_in    = '0;
               res_record_in = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_number_in = res_number_ff;
               rsp_start_in  = res_start_ff;
               rsp_end_in    = res_end_ff;
               rsp_record_in = res_record_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, config register, search and result registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pending_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            entry_count_ff <= csr_wr_data;
         end
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      addr_ff       <= addr_in;
      res_found_ff  <= res_found_in;
      res_number_ff <= res_number_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      res_record_ff <= res_record_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_number_ff <= rsp_number_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_record_ff <= rsp_record_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_entry_number = rsp_number_ff;
   assign rsp_match_start  = rsp_start_ff;
   assign rsp_match_end    = rsp_end_ff;
   assign rsp_match_record = rsp_record_ff;

endmodule

`default_nettype wire

/* design/iprtl_ram.sv */
`default_nettype none

module iprtl_ram #(
   parameter int WIDTH = iprtl_pkg::ENTRY_W,
   parameter int DEPTH = iprtl_pkg::DEF_MAX_ENTRIES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/iprtl_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module iprtl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_kind,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [iprtl_pkg::COUNT_W-1:0] rsp_entry_number,
   input logic [iprtl_pkg::WORD_W-1:0]  rsp_match_start,
   input logic [iprtl_pkg::WORD_W-1:0]  rsp_match_end,
   input logic [iprtl_pkg::WORD_W-1:0]  rsp_match_record
);

   import iprtl_pkg::*;

   // a stalled response word holds valid, found, entry number and record
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) && $stable(rsp_entry_number) && $stable(rsp_match_record)))

   // a miss carries all-zero match fields
   `ASSERT_NEVER(a_miss_zero, clock, reset, rsp_valid && !rsp_found && ((rsp_entry_number != '0) || (rsp_match_start != '0) || (rsp_match_end != '0) || (rsp_match_record != '0)))

   // a hit names a real entry whose range is not inverted
   `ASSERT_NEVER(a_hit_sane, clock, reset, rsp_valid && rsp_found && ((rsp_entry_number == '0) || (rsp_match_start > rsp_match_end)))

   // a query occupies the block, a load does not
   `ASSERT_CLK(a_query_busy, clock, reset, (req_valid && req_ready && (req_kind == KIND_QUERY)) |=> !req_ready)
   `ASSERT_CLK(a_load_free, clock, reset, (req_valid && req_ready && (req_kind == KIND_LOAD)) |=> req_ready)

endmodule

bind ip_range_table_lookup iprtl_checker u_iprtl_checker (.*);

`default_nettype wire
